>>> src/purrl_pkg.sv
// ----------------------------------------------------------------------------
// Rate limiter package
// Shared types and constants for the per-user, per-route rate limiter.
// ----------------------------------------------------------------------------
package purrl_pkg;

  // Fixed field widths of the request, result and configuration beats.
  localparam int unsigned LIMIT_BITS   = 8;
  localparam int unsigned WINDOW_BITS  = 16;
  localparam int unsigned REQ_TIME_BITS = 32;
  localparam int unsigned TOTAL_BITS   = 32;
  localparam int unsigned ROUTE_BITS   = 2;
  localparam int unsigned CFG_IDX_BITS = 3;
  localparam int unsigned CFG_DATA_BITS = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_ROUTE0_LIMIT  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ROUTE0_WINDOW = 3'd4;

  // Reset values of the route registers.
  localparam logic [LIMIT_BITS-1:0]  RST_LIMIT0 = 8'd5;
  localparam logic [LIMIT_BITS-1:0]  RST_LIMIT1 = 8'd10;
  localparam logic [LIMIT_BITS-1:0]  RST_LIMIT2 = 8'd3;
  localparam logic [LIMIT_BITS-1:0]  RST_LIMIT3 = 8'd2;
  localparam logic [WINDOW_BITS-1:0] RST_WINDOW = 16'd60;

  // Verdict codes.
  typedef enum logic [1:0] {
    VERDICT_ALLOW      = 2'd0,
    VERDICT_INVALID    = 2'd1,
    VERDICT_NO_ROUTE   = 2'd2,
    VERDICT_LIMIT_HIT  = 2'd3
  } verdict_e;

endpackage

>>> src/per_user_route_rate_limiter_core.sv
// ----------------------------------------------------------------------------
// Per-user, per-route rate limiter core
// Fixed-window token buckets, one per user and route, kept in one memory.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle while busy is low and answers
// each with a single result beat, marked by result_valid_o, registered through
// stage one and the result registers; the receiver cannot stall it, so each
// result must be taken as it appears. The rate is set by the bucket memory's
// single read-modify-write per request: the read is issued as the request is
// taken, the write goes back in the following cycle, and a register forwards
// that write to a request for the same bucket that follows directly. After
// reset the block clears the valid marks of all buckets, one per cycle, with
// busy high; configuration writes are taken during that pass.
module per_user_route_rate_limiter_core #(
  parameter int unsigned USER_BITS   = 10,
  parameter int unsigned ROUTE_COUNT = 4,
  parameter int unsigned TOKEN_BITS  = 8,
  parameter int unsigned TIME_BITS   = 32
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  // Request channel
  input  logic                                       start,
  output logic                                       busy,
  input  logic [USER_BITS-1:0]                       user_id_i,
  input  logic [purrl_pkg::ROUTE_BITS-1:0]           route_index_i,
  input  logic                                       route_hit_i,
  input  logic                                       fields_valid_i,
  input  logic [purrl_pkg::REQ_TIME_BITS-1:0]        req_time_i,
  // Result channel
  output logic                                       result_valid_o,
  output purrl_pkg::verdict_e                        verdict_o,
  output logic [purrl_pkg::LIMIT_BITS-1:0]           requests_used_o,
  output logic [purrl_pkg::LIMIT_BITS-1:0]           route_limit_out_o,
  output logic [purrl_pkg::TOTAL_BITS-1:0]           allowed_total_o,
  output logic [purrl_pkg::TOTAL_BITS-1:0]           blocked_total_o,
  // Configuration write channel
  input  logic                                       cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  logic [purrl_pkg::CFG_IDX_BITS-1:0]         cfg_index_i,
  input  logic [purrl_pkg::CFG_DATA_BITS-1:0]        cfg_data_i
);
  import purrl_pkg::*;

  localparam int unsigned SLOT_BITS = USER_BITS + ROUTE_BITS;
  localparam int unsigned SLOTS     = 1 << SLOT_BITS;
  localparam int unsigned CW        = (TOKEN_BITS > LIMIT_BITS) ? TOKEN_BITS : LIMIT_BITS;
  localparam logic [CW-1:0] TOKEN_MAX = CW'((1 << TOKEN_BITS) - 1);

  typedef struct packed {
    logic                  vld;
    logic [TOKEN_BITS-1:0] tok;
    logic [TIME_BITS-1:0]  last;
  } entry_t;

  // Route configuration registers.
  logic [LIMIT_BITS-1:0]  limit_q  [4];
  logic [WINDOW_BITS-1:0] window_q [4];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q[0]  <= RST_LIMIT0;
      limit_q[1]  <= RST_LIMIT1;
      limit_q[2]  <= RST_LIMIT2;
      limit_q[3]  <= RST_LIMIT3;
      window_q[0] <= RST_WINDOW;
      window_q[1] <= RST_WINDOW;
      window_q[2] <= RST_WINDOW;
      window_q[3] <= RST_WINDOW;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i < CFG_ROUTE0_WINDOW) begin
        limit_q[cfg_index_i[ROUTE_BITS-1:0]] <= cfg_data_i[LIMIT_BITS-1:0];
      end else begin
        window_q[cfg_index_i[ROUTE_BITS-1:0]] <= cfg_data_i;
      end
    end
  end

  // Clearing pass over the bucket memory after reset.
  logic                 clearing_q;
  logic [SLOT_BITS-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clearing_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == SLOT_BITS'(SLOTS - 1)) begin
        clearing_q <= 1'b0;
      end
    end
  end

  assign busy = clearing_q;

  // Request decode at the accepting edge.
  logic                 accept;
  logic                 route_ok;
  logic [SLOT_BITS-1:0] in_slot;
  logic [TIME_BITS+REQ_TIME_BITS-1:0] time_ext;

  assign accept   = start && !busy;
  assign route_ok = route_hit_i && ({1'b0, route_index_i} < (ROUTE_BITS + 1)'(ROUTE_COUNT));
  assign in_slot  = {user_id_i, route_index_i};
  assign time_ext = {{TIME_BITS{1'b0}}, req_time_i};

  // Stage one: request held while its bucket is read.
  logic                 s1_vld_q;
  logic                 s1_check_q;
  verdict_e             s1_verdict_q;
  logic [SLOT_BITS-1:0] s1_slot_q;
  logic [ROUTE_BITS-1:0] s1_route_q;
  logic [TIME_BITS-1:0] s1_now_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_check_q   <= fields_valid_i && route_ok;
      s1_verdict_q <= !fields_valid_i ? VERDICT_INVALID : VERDICT_NO_ROUTE;
      s1_slot_q    <= in_slot;
      s1_route_q   <= route_index_i;
      s1_now_q     <= time_ext[TIME_BITS-1:0];
    end
  end

  // Bucket memory: one write port, one registered read port.
  entry_t mem_q [SLOTS];
  entry_t rd_q;
  logic   wr_en;
  entry_t wr_data;

  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      mem_q[clr_addr_q] <= '0;
    end else if (wr_en) begin
      mem_q[s1_slot_q] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q <= mem_q[in_slot];
    end
  end

  // Last write, forwarded to a request that read the same bucket at that edge.
  logic                 fwd_vld_q;
  logic [SLOT_BITS-1:0] fwd_slot_q;
  entry_t               fwd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_vld_q <= 1'b0;
    end else begin
      fwd_vld_q <= wr_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      fwd_slot_q <= s1_slot_q;
      fwd_data_q <= wr_data;
    end
  end

  // Bucket update: first fill, window refill, token spend.
  entry_t                 cur;
  logic [LIMIT_BITS-1:0]  limit;
  logic [CW-1:0]          limit_ext;
  logic [CW-1:0]          fill_ext;
  logic [TOKEN_BITS-1:0]  fill;
  logic [TIME_BITS+WINDOW_BITS-1:0] window_ext;
  logic [TOKEN_BITS-1:0]  tok0;
  logic [TIME_BITS-1:0]   last0;
  logic [TIME_BITS-1:0]   diff;
  logic                   refill;
  logic [TOKEN_BITS-1:0]  tok1;
  logic [TIME_BITS-1:0]   last1;
  logic                   allow;
  logic [TOKEN_BITS-1:0]  tok2;
  logic [CW+TOKEN_BITS-1:0] tok_wide;
  logic [CW-1:0]          tok_ext;
  logic [CW-1:0]          used;

  always_comb begin
    cur        = (fwd_vld_q && fwd_slot_q == s1_slot_q) ? fwd_data_q : rd_q;
    limit      = limit_q[s1_route_q];
    limit_ext  = CW'(limit);
    fill_ext   = (limit_ext > TOKEN_MAX) ? TOKEN_MAX : limit_ext;
    fill       = fill_ext[TOKEN_BITS-1:0];
    window_ext = {{TIME_BITS{1'b0}}, window_q[s1_route_q]};
    tok0       = cur.vld ? cur.tok : fill;
    last0      = cur.vld ? cur.last : s1_now_q;
    diff       = s1_now_q - last0;
    refill     = !diff[TIME_BITS-1] && (diff >= window_ext[TIME_BITS-1:0]);
    tok1       = refill ? fill : tok0;
    last1      = refill ? s1_now_q : last0;
    allow      = (tok1 != '0);
    tok2       = allow ? tok1 - 1'b1 : tok1;
    tok_wide   = {{CW{1'b0}}, tok2};
    tok_ext    = tok_wide[CW-1:0];
    used       = (limit_ext > tok_ext) ? limit_ext - tok_ext : '0;
    wr_en      = s1_vld_q && s1_check_q;
    wr_data    = '{vld: 1'b1, tok: tok2, last: last1};
  end

  // Result registers and running totals.
  logic                  res_vld_q;
  verdict_e              verdict_q;
  logic [LIMIT_BITS-1:0] used_q;
  logic [LIMIT_BITS-1:0] limit_out_q;
  logic [TOTAL_BITS-1:0] allowed_q;
  logic [TOTAL_BITS-1:0] blocked_q;
  verdict_e              verdict_d;

  assign verdict_d = !s1_check_q ? s1_verdict_q : (allow ? VERDICT_ALLOW : VERDICT_LIMIT_HIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
      allowed_q <= '0;
      blocked_q <= '0;
    end else begin
      res_vld_q <= s1_vld_q;
      if (s1_vld_q) begin
        if (verdict_d == VERDICT_ALLOW) begin
          allowed_q <= allowed_q + 1'b1;
        end else begin
          blocked_q <= blocked_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      verdict_q   <= verdict_d;
      used_q      <= s1_check_q ? used[LIMIT_BITS-1:0] : '0;
      limit_out_q <= s1_check_q ? limit : '0;
    end
  end

  assign result_valid_o    = res_vld_q;
  assign verdict_o         = verdict_q;
  assign requests_used_o   = used_q;
  assign route_limit_out_o = limit_out_q;
  assign allowed_total_o   = allowed_q;
  assign blocked_total_o   = blocked_q;

endmodule

>>> src/purrl_checker.sv
// ----------------------------------------------------------------------------
// Rate limiter port checker
// Watches the request and result ports of the rate limiter over time.
// ----------------------------------------------------------------------------
module purrl_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                start,
  input logic                                busy,
  input logic                                result_valid_o,
  input purrl_pkg::verdict_e                 verdict_o,
  input logic [purrl_pkg::LIMIT_BITS-1:0]    requests_used_o,
  input logic [purrl_pkg::LIMIT_BITS-1:0]    route_limit_out_o,
  input logic [purrl_pkg::TOTAL_BITS-1:0]    allowed_total_o,
  input logic [purrl_pkg::TOTAL_BITS-1:0]    blocked_total_o
);
  import purrl_pkg::*;

  // Every accepted beat gives a result, and no result appears without one.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 result_valid_o)
    else $error("accepted request gave no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, 2))
    else $error("result without a request");

  // An allowed result steps the allowed total by one and leaves the other.
  a_allow_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && verdict_o == VERDICT_ALLOW) |->
      (allowed_total_o == $past(allowed_total_o) + 1'b1) && $stable(blocked_total_o))
    else $error("allowed total out of step");

  // Totals move only with a result.
  a_totals_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !result_valid_o |-> $stable(allowed_total_o) && $stable(blocked_total_o))
    else $error("total changed without a result");

  // A request that skipped the limit check reports no usage.
  a_skip_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (verdict_o == VERDICT_INVALID || verdict_o == VERDICT_NO_ROUTE)) |->
      (requests_used_o == '0) && (route_limit_out_o == '0))
    else $error("skipped request reports usage");

endmodule

bind per_user_route_rate_limiter_core purrl_checker u_purrl_checker (.*);
